// ----- sv/x86d_pkg.sv -----
`timescale 1ns / 1ps

package x86d_pkg;

    localparam int MAX_LEN_DEF = 15;

    localparam logic [7:0] PFX_ES  = 8'h26;
    localparam logic [7:0] PFX_REP = 8'hF3;
    localparam logic [7:0] OP_CALLF = 8'h9A;
    localparam logic [7:0] OP_IMUL_W = 8'h69;
    localparam logic [7:0] OP_IMUL_B = 8'h6B;
    localparam logic [7:0] OP_SHIFT1 = 8'hD1;
    localparam logic [7:0] OP_GRP1_W = 8'h81;
    localparam logic [7:0] OP_GRP1_B = 8'h83;
    localparam logic [7:0] OP_CALLN = 8'hE8;

    localparam logic [2:0] SEG_ES   = 3'd0;
    localparam logic [2:0] SEG_NONE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_OP   = 3'd1;
    localparam logic [2:0] ST_BAD_GRP  = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       sync;
    } code_t;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [2:0]         seg_override;
        logic               rep_prefix;
        logic               has_modrm;
        logic [1:0]         mod_field;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [15:0]        far_segment;
        logic [3:0]         length;
        logic [2:0]         status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic       modrm;
        logic       direct;
        logic [2:0] grp;
        logic [2:0] isz;
    } cls_t;

    function automatic cls_t classify(input logic [7:0] op);
        cls_t c;
        c = '0;
        c.valid = 1'b1;
        priority if (op >= 8'h40 && op <= 8'h5F)
        begin
        end
        else if ((op >= 8'h72 && op <= 8'h77) || (op >= 8'h7C && op <= 8'h7F))
        begin
            c.isz = 3'd1;
        end
        else if (op >= 8'h88 && op <= 8'h8E)
        begin
            c.modrm = 1'b1;
        end
        else if (op >= 8'hA0 && op <= 8'hA3)
        begin
            c.direct = 1'b1;
        end
        else if (op >= 8'hB0 && op <= 8'hB7)
        begin
            c.isz = 3'd1;
        end
        else if (op >= 8'hB8 && op <= 8'hBF)
        begin
            c.isz = 3'd2;
        end
        else
        begin
            unique case (op)
                8'h06, 8'h07, 8'h0E, 8'h16, 8'h1E, 8'h1F, 8'h91, 8'h92, 8'h98,
                8'h99, 8'hA4, 8'hA5, 8'hAA, 8'hAC, 8'hC9, 8'hCB, 8'hEE, 8'hFC:
                begin
                end
                8'h3C, 8'h6A, 8'h79, 8'hCD, 8'hE2, 8'hEB:
                    c.isz = 3'd1;
                8'h05, 8'h2D, 8'h3D, 8'h68, 8'hC2, 8'hCA, OP_CALLN, 8'hE9:
                    c.isz = 3'd2;
                OP_CALLF:
                    c.isz = 3'd4;
                8'h01, 8'h03, 8'h08, 8'h09, 8'h13, 8'h1B, 8'h28, 8'h29, 8'h2B,
                8'h30, 8'h31, 8'h32, 8'h38, 8'h3A, 8'h3B, 8'h84, 8'hC4, 8'hC5:
                    c.modrm = 1'b1;
                OP_IMUL_B, 8'hC6:
                begin
                    c.modrm = 1'b1;
                    c.isz = 3'd1;
                end
                OP_IMUL_W, 8'hC7:
                begin
                    c.modrm = 1'b1;
                    c.isz = 3'd2;
                end
                8'h80, OP_GRP1_B:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd1;
                    c.isz = 3'd1;
                end
                OP_GRP1_W:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd1;
                    c.isz = 3'd2;
                end
                8'hC1:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd2;
                    c.isz = 3'd1;
                end
                OP_SHIFT1:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd2;
                end
                8'hF7:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd3;
                end
                8'hFE:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd4;
                end
                8'hFF:
                begin
                    c.modrm = 1'b1;
                    c.grp = 3'd5;
                end
                default:
                    c = '0;
            endcase
        end
        return c;
    endfunction

    // permitted reg sub-operations per group
    function automatic logic grp_ok(input logic [2:0] grp, input logic [2:0] sub);
        logic [7:0] mask;
        unique case (grp)
            3'd1:    mask = 8'hAD;
            3'd2:    mask = 8'h30;
            3'd3:    mask = 8'hDC;
            3'd4:    mask = 8'h03;
            3'd5:    mask = 8'h4B;
            default: mask = 8'h00;
        endcase
        return mask[sub];
    endfunction

endpackage

// ----- sv/x86d_code_if.sv -----
`timescale 1ns / 1ps

interface x86d_code_if
    import x86d_pkg::*;
();
    logic  valid;
    logic  ready;
    code_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/x86d_result_if.sv -----
`timescale 1ns / 1ps

interface x86d_result_if
    import x86d_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/x86d_decode.sv -----
`timescale 1ns / 1ps

module x86d_decode
    import x86d_pkg::*;
#(
    parameter int MaxLen = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  code_t      code,
    output logic       emit,
    output result_t    res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MODRM = 2'd1;
    localparam logic [1:0] PH_DISP  = 2'd2;
    localparam logic [1:0] PH_IMM   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  op_reg, op_next;
    logic [1:0]  flags_reg, flags_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [31:0] imm_reg, imm_next;
    logic [2:0]  left_reg, left_next;
    logic [3:0]  len_reg, len_next;

    function automatic logic [2:0] disp_size(input logic [7:0] m);
        logic [2:0] s;
        unique case (m[7:6])
            2'd0:    s = (m[2:0] == 3'd6) ? 3'd2 : 3'd0;
            2'd1:    s = 3'd1;
            2'd2:    s = 3'd2;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    always_comb
    begin
        logic [1:0]  p;
        logic [7:0]  op;
        logic [1:0]  fl;
        logic [7:0]  mr;
        logic [15:0] dsp;
        logic [31:0] imm;
        logic [2:0]  left;
        logic [3:0]  len;
        logic [2:0]  st;
        logic        mseen;
        logic [2:0]  ds;
        logic [2:0]  idx;
        logic [7:0]  b;
        cls_t        c;

        b = code.code_byte;
        p = phase_reg;
        op = op_reg;
        fl = flags_reg;
        mr = modrm_reg;
        dsp = disp_reg;
        imm = imm_reg;
        left = left_reg;
        len = len_reg;
        if (code.sync)
        begin
            p = PH_IDLE;
            op = '0;
            fl = '0;
            mr = '0;
            dsp = '0;
            imm = '0;
            left = '0;
            len = '0;
        end
        len = len + 4'd1;
        c = classify(op);
        emit = 1'b0;
        st = ST_OK;
        mseen = 1'b0;
        ds = '0;
        idx = '0;

        unique case (p)
            PH_IDLE:
            begin
                if (b == PFX_ES)
                begin
                    fl[0] = 1'b1;
                end
                else if (b == PFX_REP)
                begin
                    fl[1] = 1'b1;
                end
                else
                begin
                    op = b;
                    c = classify(b);
                    if (!c.valid)
                    begin
                        emit = 1'b1;
                        st = ST_BAD_OP;
                    end
                    else if (c.modrm)
                    begin
                        p = PH_MODRM;
                    end
                    else if (c.direct)
                    begin
                        p = PH_DISP;
                        left = 3'd2;
                    end
                    else if (c.isz != 3'd0)
                    begin
                        p = PH_IMM;
                        left = c.isz;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            PH_MODRM:
            begin
                mr = b;
                ds = disp_size(b);
                if (c.grp != 3'd0 && !grp_ok(c.grp, b[5:3]))
                begin
                    emit = 1'b1;
                    st = ST_BAD_GRP;
                    mseen = 1'b1;
                end
                else if (b[7:6] != 2'd3 && b[2:0] <= 3'd2)
                begin
                    emit = 1'b1;
                    st = ST_BAD_ADDR;
                    mseen = 1'b1;
                end
                else if (ds != 3'd0)
                begin
                    p = PH_DISP;
                    left = ds;
                end
                else if (c.isz != 3'd0)
                begin
                    p = PH_IMM;
                    left = c.isz;
                end
                else
                begin
                    emit = 1'b1;
                    mseen = 1'b1;
                end
            end
            PH_DISP:
            begin
                ds = c.direct ? 3'd2 : disp_size(mr);
                idx = ds - left;
                if (idx[0])
                begin
                    dsp[15:8] = dsp[15:8] | b;
                end
                else
                begin
                    dsp[7:0] = dsp[7:0] | b;
                end
                left = left - 3'd1;
                if (left == 3'd0)
                begin
                    if (c.isz != 3'd0)
                    begin
                        p = PH_IMM;
                        left = c.isz;
                    end
                    else
                    begin
                        emit = 1'b1;
                        mseen = c.modrm;
                    end
                end
            end
            default:
            begin
                idx = c.isz - left;
                unique case (idx[1:0])
                    2'd0:    imm[7:0] = imm[7:0] | b;
                    2'd1:    imm[15:8] = imm[15:8] | b;
                    2'd2:    imm[23:16] = imm[23:16] | b;
                    default: imm[31:24] = imm[31:24] | b;
                endcase
                left = left - 3'd1;
                if (left == 3'd0)
                begin
                    emit = 1'b1;
                    mseen = c.modrm;
                end
            end
        endcase

        if (!emit && len >= 4'(MaxLen))
        begin
            emit = 1'b1;
            st = ST_TOO_LONG;
            mseen = c.modrm && p != PH_IDLE && p != PH_MODRM;
        end

        res.opcode = op;
        res.seg_override = fl[0] ? SEG_ES : SEG_NONE;
        res.rep_prefix = fl[1];
        res.has_modrm = mseen;
        res.mod_field = mseen ? mr[7:6] : 2'd0;
        res.rm_field = mseen ? mr[2:0] : 3'd0;
        if (mseen)
        begin
            res.reg_field = mr[5:3];
        end
        else if ((op >= 8'h40 && op <= 8'h5F) || op == 8'h91 || op == 8'h92 || op >= 8'hB0
                 && op <= 8'hBF)
        begin
            res.reg_field = op[2:0];
        end
        else
        begin
            res.reg_field = 3'd0;
        end
        res.displacement = '0;
        res.immediate = '0;
        res.far_segment = '0;
        if (st == ST_OK)
        begin
            res.displacement = dsp;
            if (c.modrm && mr[7:6] == 2'd1)
            begin
                res.displacement = {{8{dsp[7]}}, dsp[7:0]};
            end
            res.immediate = imm[15:0];
            if (op == OP_IMUL_B)
            begin
                res.immediate = {{8{imm[7]}}, imm[7:0]};
            end
            if (op == OP_SHIFT1)
            begin
                res.immediate = 16'd1;
            end
            if (op == OP_CALLF)
            begin
                res.far_segment = imm[31:16];
            end
        end
        res.length = len;
        res.status = st;

        if (emit)
        begin
            phase_next = PH_IDLE;
            op_next = '0;
            flags_next = '0;
            modrm_next = '0;
            disp_next = '0;
            imm_next = '0;
            left_next = '0;
            len_next = '0;
        end
        else
        begin
            phase_next = p;
            op_next = op;
            flags_next = fl;
            modrm_next = mr;
            disp_next = dsp;
            imm_next = imm;
            left_next = left;
            len_next = len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg <= '0;
            flags_reg <= '0;
            modrm_reg <= '0;
            disp_reg <= '0;
            imm_reg <= '0;
            left_reg <= '0;
            len_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            op_reg <= op_next;
            flags_reg <= flags_next;
            modrm_reg <= modrm_next;
            disp_reg <= disp_next;
            imm_reg <= imm_next;
            left_reg <= left_next;
            len_reg <= len_next;
        end
    end

endmodule

// ----- sv/x86_real_mode_insn_decoder_top.sv -----
`timescale 1ns / 1ps
// channel   dir  payload
// code      in   code_byte, sync
// result    out  decoded fields, length, status
//
// one code byte per cycle sustained unless a result stalls; a byte passes
// an input register, the decode logic and the result register. reset clears
// the decode state to await an opcode. a stalled result holds the pipe;
// bytes keep flowing while result is taken

module x86_real_mode_insn_decoder_top
    import x86d_pkg::*;
#(
    parameter int MaxLen = MAX_LEN_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    x86d_code_if.sink     code,
    x86d_result_if.source result
);

    logic    s1_valid_reg;
    code_t   s1_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    adv;
    logic    emit;
    result_t res;

    assign adv = !out_valid_reg || result.ready;
    assign code.ready = !s1_valid_reg || adv;
    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

    x86d_decode #(
        .MaxLen (MaxLen)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_valid_reg && adv),
        .code  (s1_data_reg),
        .emit  (emit),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg && emit;
            end
            if (code.ready)
            begin
                s1_valid_reg <= code.valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && emit)
        begin
            out_data_reg <= res;
        end
        if (code.ready && code.valid)
        begin
            s1_data_reg <= code.data;
        end
    end

endmodule
